// ===== design/pmcu_pkg.sv =====
// Package: fixed-point widths and a shared saturation helper function for the Maxwell cell update.
package pmcu_pkg;
	localparam int FRAC_BITS = 16;
	localparam int CDT_W = 31;
	localparam int CX_W = 65;   // k1*f2 - k2*f1, exact
	localparam int SC_W = 64;   // c_dt * cross, exact

	function automatic logic [31:0] sat32(input logic signed [71:0] v, output logic clip);
		begin
			if (v > 72'sd2147483647) begin
				clip = 1'b1;
				sat32 = 32'h7fffffff;
			end else if (v < -72'sd2147483648) begin
				clip = 1'b1;
				sat32 = 32'h80000000;
			end else begin
				clip = 1'b0;
				sat32 = v[31:0];
			end
		end
	endfunction
endpackage

// ===== design/pmcu_cross.sv =====
// Module: one component of c_dt * (k x f), through product, difference, scale and output registers.
module pmcu_cross (
	input  logic               clk,
	input  logic               en,
	input  logic [pmcu_pkg::CDT_W-1:0] c_dt,
	input  logic signed [31:0] k1,
	input  logic signed [31:0] f2,
	input  logic signed [31:0] k2,
	input  logic signed [31:0] f1,
	output logic signed [31:0] s,
	output logic               clip
);
	logic signed [63:0] p1_s1, p2_s1;
	logic signed [31:0] c_s2;
	logic               cl_s2;
	logic signed [pmcu_pkg::SC_W-1:0] m_s3;
	logic               cl_s3;
	logic signed [pmcu_pkg::CX_W-1:0] diff;
	logic [31:0] c_n, s_n;
	logic        c_cl, s_cl;

	always_comb begin
		diff = pmcu_pkg::CX_W'(p1_s1) - pmcu_pkg::CX_W'(p2_s1);
		// arithmetic shift gives floor rounding
		c_n = pmcu_pkg::sat32(72'(diff >>> pmcu_pkg::FRAC_BITS), c_cl);
		s_n = pmcu_pkg::sat32(72'(m_s3 >>> pmcu_pkg::FRAC_BITS), s_cl);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1 <= k1 * f2;
			p2_s1 <= k2 * f1;
			c_s2  <= c_n;
			cl_s2 <= c_cl;
			m_s3  <= $signed({1'b0, c_dt}) * c_s2;
			cl_s3 <= cl_s2;
			s     <= s_n;
			clip  <= cl_s3 | s_cl;
		end
	end
endmodule

// ===== design/pstd_maxwell_cell_update.sv =====
// Top level: pipelined spectral Maxwell update of one Fourier-space cell.
// One cell is accepted per clock while s_axis_tready is high. Each half (E' from k x B,
// then B' from k x E') uses a 4-stage cross/scale pipeline; the first half adds a
// registered combine stage, and the second half combines into the one output register
// that holds the result. The whole pipeline advances only when its last stage is empty
// or being taken, so a stall holds every stage. s_axis_tdata (lowest first): e_x,e_y,e_z,
// b_x,b_y,b_z,j_x,j_y,j_z (64b each), k_x,k_y,k_z (32b each). m_axis_tdata: new_e_x..z,
// new_b_x..z (64b each), saturated (1b), zero padded.
module pstd_maxwell_cell_update (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [30:0]   cfg_wdata,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [671:0]  s_axis_tdata,   // e_x,e_y,e_z,b_x,b_y,b_z,j_x,j_y,j_z,k_x,k_y,k_z
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [391:0]  m_axis_tdata    // new_e_x..z, new_b_x..z, saturated, pad
);
	localparam int DEPTH = 10;
	logic [30:0] cdt_q;
	logic [DEPTH-1:0] vld_q;
	logic en;
	// carried payload: E,B,J,k through first half, B,E',flag through second (k only to its start)
	logic [671:0] in_d [4];
	logic signed [31:0] sa_re [3], sa_im [3], sb_re [3], sb_im [3];
	logic ca_re [3], ca_im [3], cb_re [3], cb_im [3];
	logic [31:0] ne_re [3], ne_im [3], nb_re [3], nb_im [3];
	logic ne_cr [3], ne_ci [3], nb_cr [3], nb_ci [3];
	logic [31:0] er_s5 [3], ei_s5 [3];
	logic [63:0] b_s5 [3];
	logic [95:0] k_s5;
	logic        sat_s5;
	logic        sat_d [4];
	logic        sat_n, sat_o;

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cdt_q <= '0;
			vld_q <= '0;
		end else begin
			if (cfg_we) cdt_q <= cfg_wdata;
			if (en) vld_q <= {vld_q[DEPTH-2:0], s_axis_tvalid};
		end
	end

	function automatic logic signed [31:0] hi(input logic [63:0] v);
		hi = v[63:32];
	endfunction
	function automatic logic signed [31:0] lo(input logic [63:0] v);
		lo = v[31:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			in_d[0] <= s_axis_tdata;
			for (int i = 1; i < 4; i++) in_d[i] <= in_d[i-1];
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_a
		localparam int P = (c + 1) % 3;
		localparam int Q = (c + 2) % 3;
		logic signed [31:0] kp, kq;
		logic [63:0] bp, bq;
		assign kp = s_axis_tdata[576 + 32*P +: 32];
		assign kq = s_axis_tdata[576 + 32*Q +: 32];
		assign bp = s_axis_tdata[192 + 64*P +: 64];
		assign bq = s_axis_tdata[192 + 64*Q +: 64];
		pmcu_cross u_re (.clk, .en, .c_dt(cdt_q), .k1(kp), .f2(hi(bq)), .k2(kq),
			.f1(hi(bp)), .s(sa_re[c]), .clip(ca_re[c]));
		pmcu_cross u_im (.clk, .en, .c_dt(cdt_q), .k1(kp), .f2(lo(bq)), .k2(kq),
			.f1(lo(bp)), .s(sa_im[c]), .clip(ca_im[c]));
		// combine after 4 stages; in_d[3] aligns with s
		always_comb begin
			logic [63:0] e, j;
			e = in_d[3][64*c +: 64];
			j = in_d[3][384 + 64*c +: 64];
			ne_re[c] = pmcu_pkg::sat32(72'(hi(e)) - 72'(sa_im[c]) - 72'(hi(j)), ne_cr[c]);
			ne_im[c] = pmcu_pkg::sat32(72'(lo(e)) + 72'(sa_re[c]) - 72'(lo(j)), ne_ci[c]);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				er_s5[c] <= ne_re[c];
				ei_s5[c] <= ne_im[c];
				b_s5[c]  <= in_d[3][192 + 64*c +: 64];
			end
		end
	end

	always_comb begin
		sat_n = 1'b0;
		for (int c = 0; c < 3; c++)
			sat_n |= ca_re[c] | ca_im[c] | ne_cr[c] | ne_ci[c];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s5   <= in_d[3][671:576];
			sat_s5 <= sat_n;
			sat_d[0] <= sat_s5;
			for (int i = 1; i < 4; i++) begin
				sat_d[i] <= sat_d[i-1];
			end
		end
	end

	// second half: delay lines of B and E' (3 components each, packed) to match cross latency
	logic [191:0] bd_q [4];
	logic [191:0] ed_q [4];
	always_ff @(posedge clk) begin
		if (en) begin
			bd_q[0] <= {b_s5[2], b_s5[1], b_s5[0]};
			ed_q[0] <= {er_s5[2], ei_s5[2], er_s5[1], ei_s5[1], er_s5[0], ei_s5[0]};
			for (int i = 1; i < 4; i++) begin
				bd_q[i] <= bd_q[i-1];
				ed_q[i] <= ed_q[i-1];
			end
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_b
		localparam int P = (c + 1) % 3;
		localparam int Q = (c + 2) % 3;
		logic signed [31:0] kp, kq;
		assign kp = k_s5[32*P +: 32];
		assign kq = k_s5[32*Q +: 32];
		pmcu_cross u_re (.clk, .en, .c_dt(cdt_q), .k1(kp), .f2(er_s5[Q]), .k2(kq),
			.f1(er_s5[P]), .s(sb_re[c]), .clip(cb_re[c]));
		pmcu_cross u_im (.clk, .en, .c_dt(cdt_q), .k1(kp), .f2(ei_s5[Q]), .k2(kq),
			.f1(ei_s5[P]), .s(sb_im[c]), .clip(cb_im[c]));
		always_comb begin
			logic [63:0] b;
			b = bd_q[3][64*c +: 64];
			nb_re[c] = pmcu_pkg::sat32(72'(hi(b)) + 72'(sb_im[c]), nb_cr[c]);
			nb_im[c] = pmcu_pkg::sat32(72'(lo(b)) - 72'(sb_re[c]), nb_ci[c]);
		end
	end

	always_comb begin
		sat_o = sat_d[3];
		for (int c = 0; c < 3; c++)
			sat_o |= cb_re[c] | cb_im[c] | nb_cr[c] | nb_ci[c];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {7'd0, sat_o,
				nb_re[2], nb_im[2], nb_re[1], nb_im[1], nb_re[0], nb_im[0],
				ed_q[3]};
		end
	end
endmodule
